// ----- design/bab_pkg.sv -----
// ============================================================================
// bab_pkg
// Shared widths, register indexes, reset values and result type for the
// binarize-and-boundary block.
// ============================================================================
`default_nettype none

package bab_pkg;

    // Channel and field widths
    localparam int CH_W      = 8;
    localparam int CFG_W     = 11;
    localparam int LEVEL_W   = 8;
    localparam int COORD_W   = 10;
    localparam int CFG_IDX_W = 2;
    localparam int WIN_W     = 9;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL        = 2'd2;

    // Reset values and limits
    localparam logic [CFG_W-1:0]   DEF_FRAME_WIDTH  = 11'd640;
    localparam logic [CFG_W-1:0]   DEF_FRAME_HEIGHT = 11'd480;
    localparam logic [LEVEL_W-1:0] DEF_LEVEL        = 8'd127;
    localparam int                 DEF_MAX_WIDTH    = 1024;
    localparam int                 DEF_MAX_HEIGHT   = 1024;
    localparam int                 MIN_DIM          = 3;

    // Window with all nine pixels lit
    localparam logic [WIN_W-1:0] WIN_FULL = 9'h1FF;

    typedef struct packed {
        logic [COORD_W-1:0] out_x;
        logic [COORD_W-1:0] out_y;
        logic               foreground;
        logic               border;
        logic               frame_end;
    } t_result;

endpackage

`default_nettype wire

// ----- design/bab_in_if.sv -----
// ============================================================================
// bab_in_if
// Pixel input channel: valid/ready handshake with RGB channels and pad flag.
// ============================================================================
`default_nettype none

interface bab_in_if;
    logic                     valid;
    logic                     ready;
    logic [bab_pkg::CH_W-1:0] red;
    logic [bab_pkg::CH_W-1:0] green;
    logic [bab_pkg::CH_W-1:0] blue;
    logic                     pad;

    modport source (output valid, output red, output green, output blue, output pad,
                    input ready);
    modport sink   (input valid, input red, input green, input blue, input pad,
                    output ready);
endinterface

`default_nettype wire

// ----- design/bab_out_if.sv -----
// ============================================================================
// bab_out_if
// Result output channel: valid/ready handshake with position and marks.
// ============================================================================
`default_nettype none

interface bab_out_if;
    logic                        valid;
    logic                        ready;
    logic [bab_pkg::COORD_W-1:0] out_x;
    logic [bab_pkg::COORD_W-1:0] out_y;
    logic                        foreground;
    logic                        border;
    logic                        frame_end;

    modport source (output valid, output out_x, output out_y, output foreground,
                    output border, output frame_end, input ready);
    modport sink   (input valid, input out_x, input out_y, input foreground,
                    input border, input frame_end, output ready);
endinterface

`default_nettype wire

// ----- design/binarize_and_boundary_3x3.sv -----
// ============================================================================
// binarize_and_boundary_3x3
// Streaming binarization with 3x3 boundary marking. It takes one pixel beat
// per clock unless input ready is low. A pixel is lit when any channel exceeds
// the level register; a lit pixel gets a border mark unless its whole 3x3
// neighborhood is lit, with pixels outside the frame counted as dark. The two
// previous lines live in one two-bit-wide line memory, read when a beat is
// accepted and written back in the following cycle; its reads and writes of
// one column never overlap because neighboring beats address neighboring
// columns. Results trail the input by one line and one pixel, so a frame is
// followed by frame_width+1 pad beats, and the last one carries the frame_end
// result. A result passes the window stage register and a four-entry result
// queue that decouples the output; input ready drops only when that queue
// and the stage in flight would fill it. Writing frame_width or frame_height
// restarts the frame; both clamp to the range 3 to MAX_WIDTH or MAX_HEIGHT.
// ============================================================================
`default_nettype none

module binarize_and_boundary_3x3 #(
    parameter int MAX_WIDTH  = bab_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bab_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    bab_in_if.sink                             i_pix,
    bab_out_if.source                          o_res,
    input  wire logic                          i_cfg_we,
    input  wire logic [bab_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [bab_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int XW       = $clog2(MAX_WIDTH);
    localparam int WW       = $clog2(MAX_WIDTH + 1);
    localparam int RW       = $clog2(MAX_HEIGHT + 2);
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);
    localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);
    localparam int CW       = bab_pkg::COORD_W;

    typedef struct packed {
        logic [XW-1:0] col;
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic          lit;
        logic          top_en;
        logic          mid_en;
        logic          at_c0;
        logic          close;
        logic          end_only;
        logic          px;
        logic          clr_win;
    } t_s1;

    // Configuration registers
    logic [bab_pkg::CFG_W-1:0]   r_frame_width;
    logic [bab_pkg::CFG_W-1:0]   r_frame_height;
    logic [bab_pkg::LEVEL_W-1:0] r_level;
    logic                        geo_write;

    // Position counters and pipeline
    logic [XW-1:0]            r_col, n_col;
    logic [RW-1:0]            r_row, n_row;
    logic                     r_s1_valid;
    t_s1                      r_s1, n_s1;
    logic [1:0]               r_mem_rd;
    logic [bab_pkg::WIN_W-1:0] r_win, n_win;
    logic [1:0]               r_line_mem [MAX_WIDTH];

    // Result queue
    bab_pkg::t_result r_oq [OQ_DEPTH];
    logic [OQ_AW-1:0] r_oq_wp;
    logic [OQ_AW-1:0] r_oq_rp;
    logic [OQ_CW-1:0] r_oq_cnt;

    logic [31:0]   w32, h32, x32, y32;
    logic [WW-1:0] w_eff;
    logic [RW-1:0] h_eff, h_p1;
    logic          accept, bad, lit_raw;
    logic [XW-1:0] s_col;
    logic [RW-1:0] s_row;
    logic          s_c0;

    logic                      top, mid;
    logic [2:0]                col3;
    logic [bab_pkg::WIN_W-1:0] win_old, res_win;
    logic                      emit, push, pop;
    bab_pkg::t_result          res;

    // ------------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------------
    assign geo_write = i_cfg_we &&
                       (i_cfg_idx == bab_pkg::CFG_FRAME_WIDTH ||
                        i_cfg_idx == bab_pkg::CFG_FRAME_HEIGHT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= bab_pkg::DEF_FRAME_WIDTH;
            r_frame_height <= bab_pkg::DEF_FRAME_HEIGHT;
            r_level        <= bab_pkg::DEF_LEVEL;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bab_pkg::CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                bab_pkg::CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                bab_pkg::CFG_LEVEL:        r_level        <= i_cfg_data[bab_pkg::LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (32'(r_frame_width) < bab_pkg::MIN_DIM) begin
            w32 = 32'(bab_pkg::MIN_DIM);
        end else if (32'(r_frame_width) > MAX_WIDTH) begin
            w32 = 32'(MAX_WIDTH);
        end else begin
            w32 = 32'(r_frame_width);
        end
        if (32'(r_frame_height) < bab_pkg::MIN_DIM) begin
            h32 = 32'(bab_pkg::MIN_DIM);
        end else if (32'(r_frame_height) > MAX_HEIGHT) begin
            h32 = 32'(MAX_HEIGHT);
        end else begin
            h32 = 32'(r_frame_height);
        end
    end

    assign w_eff = w32[WW-1:0];
    assign h_eff = h32[RW-1:0];
    assign h_p1  = h_eff + RW'(1);

    // ------------------------------------------------------------------------
    // Accept stage: position, threshold, line memory read
    // ------------------------------------------------------------------------
    assign i_pix.ready = (32'(r_oq_cnt) + 32'(r_s1_valid)) < OQ_DEPTH;
    assign accept      = i_pix.valid && i_pix.ready;

    always_comb begin
        bad     = (WW'(r_col) >= w_eff) || (r_row > h_p1);
        s_col   = bad ? '0 : r_col;
        s_row   = bad ? '0 : r_row;
        s_c0    = (s_col == '0);
        lit_raw = (i_pix.red > r_level) || (i_pix.green > r_level) ||
                  (i_pix.blue > r_level);

        n_s1.col      = s_col;
        n_s1.lit      = lit_raw && !i_pix.pad && (s_row < h_eff);
        n_s1.top_en   = (s_row >= RW'(2));
        n_s1.mid_en   = (s_row >= RW'(1));
        n_s1.at_c0    = s_c0;
        n_s1.close    = s_c0 && (s_row >= RW'(2));
        n_s1.end_only = s_c0 && (s_row == h_p1);
        n_s1.px       = !s_c0 && (s_row != '0);
        n_s1.clr_win  = bad;

        // The line-closing result describes the last pixel two lines up.
        if (n_s1.close) begin
            x32 = 32'(w_eff) - 32'd1;
            y32 = 32'(s_row) - 32'd2;
        end else begin
            x32 = 32'(s_col) - 32'd1;
            y32 = 32'(s_row) - 32'd1;
        end
        n_s1.x = x32[CW-1:0];
        n_s1.y = y32[CW-1:0];

        if (n_s1.end_only) begin
            n_col = '0;
            n_row = '0;
        end else if (WW'(s_col) == w_eff - WW'(1)) begin
            n_col = '0;
            n_row = s_row + RW'(1);
        end else begin
            n_col = s_col + XW'(1);
            n_row = s_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
            if (geo_write) begin
                r_col <= '0;
                r_row <= '0;
            end else if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1     <= n_s1;
            r_mem_rd <= r_line_mem[s_col];
        end
    end

    // ------------------------------------------------------------------------
    // Window stage: build the 3x3 window, write the line memory back
    // ------------------------------------------------------------------------
    always_comb begin
        top     = r_s1.top_en & r_mem_rd[1];
        mid     = r_s1.mid_en & r_mem_rd[0];
        col3    = {r_s1.lit, mid, top};
        win_old = r_s1.clr_win ? '0 : r_win;

        if (r_s1.end_only) begin
            n_win = '0;
        end else if (r_s1.at_c0) begin
            n_win = {6'b0, col3};
        end else begin
            n_win = {win_old[5:0], col3};
        end

        // Closing a line shifts in a dark column on the right.
        res_win = r_s1.close ? {win_old[5:0], 3'b000} : n_win;

        res.out_x      = r_s1.x;
        res.out_y      = r_s1.y;
        res.foreground = res_win[4];
        res.border     = res_win[4] && (res_win != bab_pkg::WIN_FULL);
        res.frame_end  = r_s1.end_only;

        emit = r_s1.close || r_s1.px;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (geo_write) begin
            r_win <= '0;
        end else if (r_s1_valid) begin
            r_win <= n_win;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid && !r_s1.end_only) begin
            r_line_mem[r_s1.col] <= {r_mem_rd[0], r_s1.lit};
        end
    end

    // ------------------------------------------------------------------------
    // Result queue
    // ------------------------------------------------------------------------
    assign push = r_s1_valid && emit;
    assign pop  = o_res.valid && o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_wp  <= '0;
            r_oq_rp  <= '0;
            r_oq_cnt <= '0;
        end else begin
            if (push) begin
                r_oq_wp <= r_oq_wp + OQ_AW'(1);
            end
            if (pop) begin
                r_oq_rp <= r_oq_rp + OQ_AW'(1);
            end
            if (push && !pop) begin
                r_oq_cnt <= r_oq_cnt + OQ_CW'(1);
            end else if (pop && !push) begin
                r_oq_cnt <= r_oq_cnt - OQ_CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_oq[r_oq_wp] <= res;
        end
    end

    assign o_res.valid      = (r_oq_cnt != '0);
    assign o_res.out_x      = r_oq[r_oq_rp].out_x;
    assign o_res.out_y      = r_oq[r_oq_rp].out_y;
    assign o_res.foreground = r_oq[r_oq_rp].foreground;
    assign o_res.border     = r_oq[r_oq_rp].border;
    assign o_res.frame_end  = r_oq[r_oq_rp].frame_end;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_no_col_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !r_s1.end_only && accept) |-> (s_col != r_s1.col))
        else $error("line memory read and write hit the same column");

    a_s1_from_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> $past(accept))
        else $error("window stage busy without an accepted beat");

    a_queue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (32'(r_oq_cnt) < OQ_DEPTH || pop))
        else $error("result pushed into a full queue");

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_oq_cnt) <= OQ_DEPTH)
        else $error("result queue count out of range");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (WW'(r_col) < w_eff) && (r_row <= h_p1))
        else $error("position counters left the frame");

endmodule

`default_nettype wire

// ----- tb/bab_checker.sv -----
`timescale 1ns / 1ps
// ============================================================================
// bab_checker
// Watches the pixel and result channels and the register port of the
// binarize-and-boundary block. It keeps its own copy of the registers, the
// two line stores and the 3x3 window. It works out the result that each
// accepted pixel beat calls for and compares every accepted result beat,
// field by field, with the oldest outstanding one.
// ============================================================================

module bab_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    bab_in_if                                  i_pix,
    bab_out_if                                 i_res,
    input  wire logic                          i_cfg_we,
    input  wire logic [bab_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [bab_pkg::CFG_W-1:0]     i_cfg_data,
    output int                                 o_mismatches,
    output int                                 o_pending
);
    import bab_pkg::*;

    logic [CFG_W-1:0]   width_reg;
    logic [CFG_W-1:0]   height_reg;
    logic [LEVEL_W-1:0] level_reg;
    bit                 row_above  [DEF_MAX_WIDTH];
    bit                 row_above2 [DEF_MAX_WIDTH];
    logic [WIN_W-1:0]   window;
    int unsigned        col_cnt;
    int unsigned        row_cnt;
    t_result            expected_marks[$];
    int                 mismatch_cnt = 0;

    function automatic int unsigned clamp_dim(logic [CFG_W-1:0] v, int unsigned hi);
        if (v < MIN_DIM) return MIN_DIM;
        if (v > hi) return hi;
        return 32'(v);
    endfunction

    // Bit 4 of the window is the pixel being described.
    function automatic t_result mark_pixel(int unsigned x, int unsigned y,
                                           logic [WIN_W-1:0] win, logic last);
        t_result res;
        res.out_x      = x[COORD_W-1:0];
        res.out_y      = y[COORD_W-1:0];
        res.foreground = win[4];
        res.border     = win[4] && (win != WIN_FULL);
        res.frame_end  = last;
        return res;
    endfunction

    function automatic void classify_pixel(logic [CH_W-1:0] red, logic [CH_W-1:0] green,
                                           logic [CH_W-1:0] blue, logic pad);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned row;
        logic        lit;
        logic        top;
        logic        mid;
        w   = clamp_dim(width_reg, DEF_MAX_WIDTH);
        h   = clamp_dim(height_reg, DEF_MAX_HEIGHT);
        c   = col_cnt;
        row = row_cnt;
        if (c >= w || row > h + 1) begin
            c      = 0;
            row    = 0;
            window = '0;
        end
        if (c == 0) begin
            // The last pixel of the previous line sees a dark column on its right.
            if (row >= 2)
                expected_marks.push_back(mark_pixel(w - 1, row - 2, {window[5:0], 3'b000},
                                                    row == h + 1));
            window = '0;
            if (row == h + 1) begin
                col_cnt = 0;
                row_cnt = 0;
                return;
            end
        end
        lit = (red > level_reg) || (green > level_reg) || (blue > level_reg);
        if (pad || row >= h) lit = 1'b0;
        top = (row >= 2) ? row_above2[c] : 1'b0;
        mid = (row >= 1) ? row_above[c] : 1'b0;
        row_above2[c] = row_above[c];
        row_above[c]  = lit;
        window = {window[5:0], lit, mid, top};
        if (c >= 1 && row >= 1)
            expected_marks.push_back(mark_pixel(c - 1, row - 1, window, 1'b0));
        c++;
        if (c >= w) begin
            c = 0;
            row++;
        end
        col_cnt = c;
        row_cnt = row;
    endfunction

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatch_cnt++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            width_reg  = DEF_FRAME_WIDTH;
            height_reg = DEF_FRAME_HEIGHT;
            level_reg  = DEF_LEVEL;
            window     = '0;
            col_cnt    = 0;
            row_cnt    = 0;
            expected_marks.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                if (expected_marks.size() == 0) begin
                    $error("result for (%0d, %0d) arrived with none outstanding",
                           i_res.out_x, i_res.out_y);
                    mismatch_cnt++;
                end else begin
                    want = expected_marks.pop_front();
                    check_field("out_x", 32'(want.out_x), 32'(i_res.out_x));
                    check_field("out_y", 32'(want.out_y), 32'(i_res.out_y));
                    check_field("foreground", 32'(want.foreground), 32'(i_res.foreground));
                    check_field("border", 32'(want.border), 32'(i_res.border));
                    check_field("frame_end", 32'(want.frame_end), 32'(i_res.frame_end));
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FRAME_WIDTH, CFG_FRAME_HEIGHT: begin
                        if (i_cfg_idx == CFG_FRAME_WIDTH)
                            width_reg = i_cfg_data;
                        else
                            height_reg = i_cfg_data;
                        // A new geometry starts a new frame.
                        col_cnt = 0;
                        row_cnt = 0;
                        window  = '0;
                    end
                    CFG_LEVEL: begin
                        level_reg = i_cfg_data[LEVEL_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_pix.valid && i_pix.ready)
                classify_pixel(i_pix.red, i_pix.green, i_pix.blue, i_pix.pad);
        end
        o_pending    <= expected_marks.size();
        o_mismatches <= mismatch_cnt;
    end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Top level for the binarize-and-boundary block. It drives pixel frames of
// many sizes and threshold levels through the block under random idling on
// both channels, with broken frames and stray pad beats mixed in, while the
// checker predicts and compares every result.
// ============================================================================

module testbench;
    import bab_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 9;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS  = 460;
    localparam int WIDE_PIXELS   = 48;
    localparam int TALL_LINES    = 24;
    localparam int CYCLE_LIMIT   = 60000;

    // Directed beats, packed as {pad, red, green, blue}.
    localparam logic [3*CH_W:0] DIRECTED_BEATS [26] = '{
        // A fully lit frame: only the center pixel has a lit neighborhood.
        {1'b0, 8'd128, 8'd0,   8'd0  }, {1'b0, 8'd0,   8'd128, 8'd0  },
        {1'b0, 8'd0,   8'd0,   8'd128}, {1'b0, 8'd255, 8'd0,   8'd0  },
        {1'b0, 8'd255, 8'd255, 8'd255}, {1'b0, 8'd0,   8'd0,   8'd255},
        {1'b0, 8'd200, 8'd1,   8'd1  }, {1'b0, 8'd1,   8'd200, 8'd1  },
        {1'b0, 8'd128, 8'd128, 8'd128},
        {1'b1, 8'd255, 8'd255, 8'd255}, {1'b1, 8'd255, 8'd255, 8'd255},
        {1'b1, 8'd255, 8'd255, 8'd255}, {1'b1, 8'd255, 8'd255, 8'd255},
        // Values at the threshold, a pad inside the frame, a pixel in the flush.
        {1'b0, 8'd127, 8'd127, 8'd127}, {1'b0, 8'd0,   8'd0,   8'd0  },
        {1'b0, 8'd255, 8'd255, 8'd255}, {1'b1, 8'd255, 8'd255, 8'd255},
        {1'b0, 8'd128, 8'd127, 8'd127}, {1'b0, 8'd127, 8'd127, 8'd128},
        {1'b0, 8'd255, 8'd255, 8'd255}, {1'b0, 8'd255, 8'd255, 8'd255},
        {1'b0, 8'd255, 8'd255, 8'd255},
        {1'b0, 8'd255, 8'd255, 8'd255}, {1'b1, 8'd0,   8'd0,   8'd0  },
        {1'b1, 8'd0,   8'd0,   8'd0  }, {1'b1, 8'd0,   8'd0,   8'd0  }
    };

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;
    logic [LEVEL_W-1:0]   cur_level = DEF_LEVEL;
    int unsigned          send_idle_pct = 0;
    int unsigned          recv_stall_pct = 0;
    int unsigned          beats_sent = 0;
    int unsigned          cycle_cnt = 0;
    int                   mismatches;
    int                   pending;

    bab_in_if  pix_if ();
    bab_out_if res_if ();

    binarize_and_boundary_3x3 DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_pix      (pix_if),
        .o_res      (res_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    bab_checker checker_inst (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_pix        (pix_if),
        .i_res        (res_if),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    always #CLK_HALF clk = ~clk;

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("binarize_and_boundary_3x3 test failed");
            $finish;
        end
    end

    always @(posedge clk) begin
        res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic set_idling(int unsigned phase);
        case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
            default: begin send_idle_pct = 7; recv_stall_pct = 7; end
        endcase
    endtask

    task automatic send_beat(logic [CH_W-1:0] red, logic [CH_W-1:0] green,
                             logic [CH_W-1:0] blue, logic pad);
        while ($urandom_range(99) < send_idle_pct) begin
            pix_if.valid <= 1'b0;
            @(posedge clk);
        end
        pix_if.valid <= 1'b1;
        pix_if.red   <= red;
        pix_if.green <= green;
        pix_if.blue  <= blue;
        pix_if.pad   <= pad;
        @(posedge clk);
        while (!pix_if.ready) @(posedge clk);
        beats_sent++;
    endtask

    // Channel values are often placed right at the threshold.
    task automatic send_pixel(bit lit, bit pad);
        logic [2:0]      hot;
        logic [CH_W-1:0] ch [3];
        hot = (lit && cur_level != 8'd255) ? 3'($urandom_range(7, 1)) : 3'b000;
        for (int k = 0; k < 3; k++) begin
            if (hot[k])
                ch[k] = ($urandom_range(3) == 0) ? cur_level + 8'd1
                                                 : 8'($urandom_range(255, cur_level + 1));
            else
                ch[k] = ($urandom_range(3) == 0) ? cur_level
                                                 : 8'($urandom_range(cur_level, 0));
        end
        send_beat(ch[0], ch[1], ch[2], pad);
    endtask

    task automatic send_frame(int unsigned w, int unsigned npix, int unsigned density,
                              int unsigned noise, bit flush);
        for (int unsigned i = 0; i < npix; i++)
            send_pixel($urandom_range(99) < density, $urandom_range(99) < noise);
        if (flush) begin
            for (int unsigned i = 0; i <= w; i++) begin
                if ($urandom_range(99) < noise)
                    send_pixel(1'b1, 1'b0);
                else
                    send_beat(8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
            end
        end
    endtask

    // Registers change only once the block has gone quiet.
    task automatic settle();
        pix_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value[CFG_W-1:0];
        if (idx == CFG_LEVEL) cur_level = value[LEVEL_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic int unsigned pick_level();
        case ($urandom_range(3))
            0: return 0;
            1: return 255;
            default: return $urandom_range(255);
        endcase
    endfunction

    initial begin
        int unsigned w;
        int unsigned h;
        int unsigned kind;
        int unsigned density;
        int unsigned noise;
        int unsigned npix;
        int unsigned frame_idx;
        int unsigned rand_start;
        bit          carry_on;
        bit          flush;

        pix_if.valid = 1'b0;
        pix_if.red   = '0;
        pix_if.green = '0;
        pix_if.blue  = '0;
        pix_if.pad   = 1'b0;
        cfg_we       = 1'b0;
        cfg_idx      = CFG_FRAME_WIDTH;
        cfg_data     = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Two back-to-back 3x3 frames at the reset level.
        write_reg(CFG_FRAME_WIDTH, 3);
        write_reg(CFG_FRAME_HEIGHT, 3);
        foreach (DIRECTED_BEATS[i])
            send_beat(DIRECTED_BEATS[i][23:16], DIRECTED_BEATS[i][15:8],
                      DIRECTED_BEATS[i][7:0], DIRECTED_BEATS[i][24]);

        // Mostly whole frames; some noisy, cut short, or running into the next
        // frame without a flush.
        w          = 3;
        h          = 3;
        frame_idx  = 0;
        carry_on   = 1'b0;
        rand_start = beats_sent;
        while (beats_sent - rand_start < RANDOM_ITEMS) begin
            set_idling(frame_idx % 4);
            kind = $urandom_range(99);
            if (!carry_on) begin
                w = $urandom_range(12, 3);
                h = $urandom_range(8, 3);
                settle();
                if (kind < 30) write_reg(CFG_LEVEL, pick_level());
                write_reg(CFG_FRAME_WIDTH, (w == MIN_DIM && kind[0]) ? $urandom_range(2) : w);
                write_reg(CFG_FRAME_HEIGHT, (h == MIN_DIM && kind[1]) ? $urandom_range(2) : h);
            end
            case ($urandom_range(2))
                0: density = 50;
                1: density = 85;
                default: density = 97;
            endcase
            noise    = (kind >= 80 && kind < 92) ? 15 : 0;
            npix     = (kind >= 92) ? $urandom_range(w * h - 1, 1) : w * h;
            carry_on = (kind >= 70 && kind < 80);
            flush    = (kind < 92) && !carry_on;
            send_frame(w, npix, density, noise, flush);
            frame_idx++;
        end

        // Oversized width: the start of the widest line must stay silent.
        settle();
        set_idling($urandom_range(3));
        write_reg(CFG_LEVEL, 100);
        write_reg(CFG_FRAME_WIDTH, 2047);
        write_reg(CFG_FRAME_HEIGHT, 3);
        send_frame(DEF_MAX_WIDTH, WIDE_PIXELS, 95, 0, 1'b0);

        // Oversized height at the narrowest width: lines run past any small frame.
        settle();
        set_idling($urandom_range(3));
        write_reg(CFG_FRAME_WIDTH, 0);
        write_reg(CFG_FRAME_HEIGHT, 2047);
        send_frame(MIN_DIM, MIN_DIM * TALL_LINES, 80, 5, 1'b0);

        settle();
        if (mismatches == 0 && pending == 0)
            $display("binarize_and_boundary_3x3 test passed");
        else
            $display("binarize_and_boundary_3x3 test failed");
        $finish;
    end

endmodule

// ----- sim.f -----
design/bab_pkg.sv
design/bab_in_if.sv
design/bab_out_if.sv
design/binarize_and_boundary_3x3.sv
tb/bab_checker.sv
tb/testbench.sv
